/* rtl/core/pressure_temp_compensation_defines.svh */
// assertion macros for the pressure and temperature compensation block
`ifndef PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`ifndef SYNTH
`define PTC_ASSERT_IMP(lbl, pre, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (con)) \
        else $error("ptc check failed");
`define PTC_ASSERT_DLY(lbl, pre, n, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> ##n (con)) \
        else $error("ptc latency check failed");
`else
`define PTC_ASSERT_IMP(lbl, pre, con)
`define PTC_ASSERT_DLY(lbl, pre, n, con)
`endif
`endif

/* rtl/core/ptc_pkg.sv */
// shared types and constants of the pressure and temperature compensation block
package ptc_pkg;

    localparam int TDIV_STAGES = 27;
    localparam int PDIV_STAGES = 32;
    localparam int MID_STAGES  = 9;
    localparam int PTC_LATENCY = 3 + TDIV_STAGES + MID_STAGES + PDIV_STAGES + 3;

    localparam int B6_OFFSET = 4000;
    localparam int P_SCALE   = 50000;
    localparam int K_SQ      = 3038;
    localparam int K_LIN     = 7357;
    localparam int K_SUM     = 3791;
    localparam int B4_BIAS   = 32768;
    localparam int PRESS_MAX = 1048575;

    typedef enum logic [2:0] {
        CFG_AC123 = 3'd0,
        CFG_AC456 = 3'd1,
        CFG_B12   = 3'd2,
        CFG_MBMD  = 3'd3,
        CFG_OSS   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic [1:0]         oss;
    } t_coeff;

    typedef struct packed {
        logic signed [18:0] x1;
        logic [18:0]        up;
        logic               dz;
        logic               neg;
    } t_tdiv_pay;

    typedef struct packed {
        logic signed [15:0] t16;
        logic               dz;
        logic               bz;
        logic               hi;
    } t_pdiv_pay;

endpackage

/* rtl/core/pressure_temp_compensation.sv */
// top level: calibration registers, front stages, dividers and pressure correction
//
// channel   direction  handshake                 payload
// command   in         start && !busy            i_raw_temp, i_raw_press
// result    out        o_strobe, one cycle       o_temperature, o_pressure, flags
// config    in         i_cfg_valid && ready      i_cfg_index, i_cfg_data
//
// one word per cycle; o_strobe rises when the result of a command leaves the tail registers
// the pipeline holds the front stages, the two bit-per-stage dividers (27 and 32 stages), the middle and the tail
// synchronous active-low reset clears the config registers and valid bits and empties the pipeline
// busy stays low and the pipeline never stalls
module pressure_temp_compensation import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_raw_temp,
    input  logic [23:0]        i_raw_press,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    output logic               o_strobe,
    output logic signed [15:0] o_temperature,
    output logic [19:0]        o_pressure,
    output logic               o_calib_invalid,
    output logic               o_div_fault
);

`include "pressure_temp_compensation_defines.svh"

    logic [47:0] r_ac123;
    logic [47:0] r_ac456;
    logic [31:0] r_b12;
    logic [47:0] r_mbmd;
    logic [1:0]  r_oss;

    t_coeff             s_cf;
    logic [15:0]        s_ac5;
    logic [15:0]        s_ac6;
    logic signed [15:0] s_mc;
    logic signed [15:0] s_md;
    logic               s_calib;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac123 <= '0;
            r_ac456 <= '0;
            r_b12   <= '0;
            r_mbmd  <= '0;
            r_oss   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_AC123: r_ac123 <= i_cfg_data;
                CFG_AC456: r_ac456 <= i_cfg_data;
                CFG_B12:   r_b12   <= i_cfg_data[31:0];
                CFG_MBMD:  r_mbmd  <= i_cfg_data;
                CFG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_cf.ac1 = r_ac123[47:32];
        s_cf.ac2 = r_ac123[31:16];
        s_cf.ac3 = r_ac123[15:0];
        s_cf.ac4 = r_ac456[47:32];
        s_cf.b1  = r_b12[31:16];
        s_cf.b2  = r_b12[15:0];
        s_cf.oss = r_oss;
        s_ac5    = r_ac456[31:16];
        s_ac6    = r_ac456[15:0];
        s_mc     = r_mbmd[31:16];
        s_md     = r_mbmd[15:0];
        s_calib  = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_ac123[16*k +: 16] == 16'h0000 || r_ac123[16*k +: 16] == 16'hffff ||
                r_ac456[16*k +: 16] == 16'h0000 || r_ac456[16*k +: 16] == 16'hffff ||
                r_mbmd[16*k +: 16] == 16'h0000 || r_mbmd[16*k +: 16] == 16'hffff) begin
                s_calib = 1'b1;
            end
        end
        for (int k = 0; k < 2; k++) begin
            if (r_b12[16*k +: 16] == 16'h0000 || r_b12[16*k +: 16] == 16'hffff) begin
                s_calib = 1'b1;
            end
        end
    end

    // front stages: raw alignment, x1 product, divisor
    logic               r_a_vld;
    logic signed [16:0] r_a_diff;
    logic [18:0]        r_a_up;
    logic               r_b_vld;
    logic signed [33:0] r_b_prod;
    logic [18:0]        r_b_up;
    logic               r_c_vld;
    logic signed [18:0] r_c_x1;
    logic signed [19:0] r_c_div;
    logic [18:0]        r_c_up;

    logic signed [18:0] s_x1;
    logic signed [26:0] s_mcn;
    logic [26:0]        s_num;
    logic [19:0]        s_den;
    t_tdiv_pay          s_tpay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    assign s_x1 = 19'(r_b_prod >>> 15);

    always_ff @(posedge i_clk) begin
        r_a_diff <= $signed({1'b0, i_raw_temp}) - $signed({1'b0, s_ac6});
        r_a_up   <= 19'(i_raw_press >> (4'd8 - {2'b00, r_oss}));
        r_b_prod <= r_a_diff * $signed({1'b0, s_ac5});
        r_b_up   <= r_a_up;
        r_c_x1   <= s_x1;
        r_c_div  <= 20'(s_x1) + 20'(s_md);
        r_c_up   <= r_b_up;
    end

    always_comb begin
        s_mcn       = {s_mc, 11'b0};
        s_num       = s_mcn[26] ? 27'(-s_mcn) : 27'(s_mcn);
        s_den       = r_c_div[19] ? 20'(-r_c_div) : 20'(r_c_div);
        s_tpay.x1   = r_c_x1;
        s_tpay.up   = r_c_up;
        s_tpay.dz   = (r_c_div == 20'sd0);
        s_tpay.neg  = s_mc[15] ^ r_c_div[19];
    end

    logic        w_td_vld;
    logic [26:0] w_td_quo;
    t_tdiv_pay   w_td_pay;

    ptc_tdiv u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_num   (s_num),
        .i_den   (s_den),
        .i_pay   (s_tpay),
        .o_vld   (w_td_vld),
        .o_quo   (w_td_quo),
        .o_pay   (w_td_pay)
    );

    logic signed [27:0] s_x2;
    logic signed [28:0] s_b5;

    always_comb begin
        s_x2 = w_td_pay.neg ? -$signed({1'b0, w_td_quo}) : $signed({1'b0, w_td_quo});
        s_b5 = 29'(w_td_pay.x1) + 29'(s_x2);
    end

    logic               w_md_vld;
    logic [16:0]        w_md_b4;
    logic [31:0]        w_md_b7;
    logic signed [15:0] w_md_t16;
    logic               w_md_dz;

    ptc_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_td_vld),
        .i_b5    (s_b5),
        .i_up    (w_td_pay.up),
        .i_dz    (w_td_pay.dz),
        .i_cf    (s_cf),
        .o_vld   (w_md_vld),
        .o_b4    (w_md_b4),
        .o_b7    (w_md_b7),
        .o_t16   (w_md_t16),
        .o_dz    (w_md_dz)
    );

    // below 2^31 b7 is doubled before dividing, otherwise the quotient is doubled
    logic [31:0] s_pnum;
    t_pdiv_pay   s_ppay;

    always_comb begin
        s_ppay.t16 = w_md_t16;
        s_ppay.dz  = w_md_dz;
        s_ppay.bz  = (w_md_b4 == 17'd0);
        s_ppay.hi  = w_md_b7[31];
        s_pnum     = w_md_b7[31] ? w_md_b7 : {w_md_b7[30:0], 1'b0};
    end

    logic        w_pd_vld;
    logic [31:0] w_pd_quo;
    t_pdiv_pay   w_pd_pay;

    ptc_pdiv u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_md_vld),
        .i_num   (s_pnum),
        .i_den   (w_md_b4),
        .i_pay   (s_ppay),
        .o_vld   (w_pd_vld),
        .o_quo   (w_pd_quo),
        .o_pay   (w_pd_pay)
    );

    // tail: second-order pressure correction
    logic [32:0]        s_p;
    logic               r_t0_vld;
    logic [49:0]        r_t0_sq;
    logic [32:0]        r_t0_p;
    t_pdiv_pay          r_t0_pay;
    logic               r_t1_vld;
    logic [45:0]        r_t1_x1;
    logic signed [31:0] r_t1_x2;
    logic [32:0]        r_t1_p;
    t_pdiv_pay          r_t1_pay;

    logic [61:0]        s_m1;
    logic signed [47:0] s_m2;
    logic signed [48:0] s_sum;
    logic signed [48:0] s_pf;
    logic [19:0]        s_pclamp;
    logic               s_fault;

    assign s_p = w_pd_pay.hi ? {w_pd_quo, 1'b0} : {1'b0, w_pd_quo};

    always_comb begin
        s_m1  = 62'(r_t0_sq) * 62'(K_SQ);
        s_m2  = -48'(K_LIN) * $signed({15'b0, r_t0_p});
        s_sum = $signed({3'b0, r_t1_x1}) + 49'(r_t1_x2) + 49'(K_SUM);
        s_pf  = $signed({16'b0, r_t1_p}) + (s_sum >>> 4);
        if (s_pf < 49'sd0) begin
            s_pclamp = 20'd0;
        end else if (s_pf > 49'(PRESS_MAX)) begin
            s_pclamp = 20'(PRESS_MAX);
        end else begin
            s_pclamp = s_pf[19:0];
        end
        s_fault = r_t1_pay.dz || r_t1_pay.bz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_vld <= 1'b0;
            r_t1_vld <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_t0_vld <= w_pd_vld;
            r_t1_vld <= r_t0_vld;
            o_strobe <= r_t1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0_sq         <= s_p[32:8] * s_p[32:8];
        r_t0_p          <= s_p;
        r_t0_pay        <= w_pd_pay;
        r_t1_x1         <= s_m1[61:16];
        r_t1_x2         <= 32'(s_m2 >>> 16);
        r_t1_p          <= r_t0_p;
        r_t1_pay        <= r_t0_pay;
        o_temperature   <= s_fault ? 16'sd0 : r_t1_pay.t16;
        o_pressure      <= s_fault ? 20'd0 : s_pclamp;
        o_calib_invalid <= s_calib;
        o_div_fault     <= s_fault;
    end

    `PTC_ASSERT_DLY(a_fixed_latency, start && !busy, PTC_LATENCY, o_strobe)
    `PTC_ASSERT_IMP(a_fault_zeroes, o_strobe && o_div_fault, o_temperature == '0 && o_pressure == '0)
    `PTC_ASSERT_IMP(a_strobe_from_tail, o_strobe, $past(r_t1_vld))

endmodule

/* rtl/core/ptc_tdiv.sv */
// pipelined restoring divider for the temperature quotient, one bit per stage
module ptc_tdiv import ptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [26:0] i_num,
    input  logic [19:0] i_den,
    input  t_tdiv_pay   i_pay,
    output logic        o_vld,
    output logic [26:0] o_quo,
    output t_tdiv_pay   o_pay
);

    logic        r_vld [TDIV_STAGES];
    logic [19:0] r_rem [TDIV_STAGES];
    logic [26:0] r_nq  [TDIV_STAGES];
    logic [19:0] r_den [TDIV_STAGES];
    t_tdiv_pay   r_pay [TDIV_STAGES];

    for (genvar k = 0; k < TDIV_STAGES; k++) begin : g_stage
        logic        s_vld;
        logic [19:0] s_rem;
        logic [19:0] s_den;
        logic [26:0] s_nq;
        t_tdiv_pay   s_pay;
        logic [20:0] s_try;
        logic [20:0] s_diff;

        if (k == 0) begin : g_first
            assign s_vld = i_vld;
            assign s_rem = '0;
            assign s_den = i_den;
            assign s_nq  = i_num;
            assign s_pay = i_pay;
        end else begin : g_next
            assign s_vld = r_vld[k-1];
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_nq  = r_nq[k-1];
            assign s_pay = r_pay[k-1];
        end

        assign s_try  = {s_rem, s_nq[26]};
        assign s_diff = s_try - {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld;
            end
        end

        // borrow clear means the divisor fits
        always_ff @(posedge i_clk) begin
            r_rem[k] <= s_diff[20] ? s_try[19:0] : s_diff[19:0];
            r_nq[k]  <= {s_nq[25:0], ~s_diff[20]};
            r_den[k] <= s_den;
            r_pay[k] <= s_pay;
        end
    end

    assign o_vld = r_vld[TDIV_STAGES-1];
    assign o_quo = r_nq[TDIV_STAGES-1];
    assign o_pay = r_pay[TDIV_STAGES-1];

endmodule

/* rtl/core/ptc_pdiv.sv */
// pipelined restoring divider for the pressure quotient, one bit per stage
module ptc_pdiv import ptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [31:0] i_num,
    input  logic [16:0] i_den,
    input  t_pdiv_pay   i_pay,
    output logic        o_vld,
    output logic [31:0] o_quo,
    output t_pdiv_pay   o_pay
);

    logic        r_vld [PDIV_STAGES];
    logic [16:0] r_rem [PDIV_STAGES];
    logic [31:0] r_nq  [PDIV_STAGES];
    logic [16:0] r_den [PDIV_STAGES];
    t_pdiv_pay   r_pay [PDIV_STAGES];

    for (genvar k = 0; k < PDIV_STAGES; k++) begin : g_stage
        logic        s_vld;
        logic [16:0] s_rem;
        logic [16:0] s_den;
        logic [31:0] s_nq;
        t_pdiv_pay   s_pay;
        logic [17:0] s_try;
        logic [17:0] s_diff;

        if (k == 0) begin : g_first
            assign s_vld = i_vld;
            assign s_rem = '0;
            assign s_den = i_den;
            assign s_nq  = i_num;
            assign s_pay = i_pay;
        end else begin : g_next
            assign s_vld = r_vld[k-1];
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_nq  = r_nq[k-1];
            assign s_pay = r_pay[k-1];
        end

        assign s_try  = {s_rem, s_nq[31]};
        assign s_diff = s_try - {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= s_diff[17] ? s_try[16:0] : s_diff[16:0];
            r_nq[k]  <= {s_nq[30:0], ~s_diff[17]};
            r_den[k] <= s_den;
            r_pay[k] <= s_pay;
        end
    end

    assign o_vld = r_vld[PDIV_STAGES-1];
    assign o_quo = r_nq[PDIV_STAGES-1];
    assign o_pay = r_pay[PDIV_STAGES-1];

endmodule

/* rtl/core/ptc_mid.sv */
// middle pipeline: b5 to b6 and to the saturated temperature, b6 squared, b3, b4 and b7
module ptc_mid import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [28:0] i_b5,
    input  logic [18:0]        i_up,
    input  logic               i_dz,
    input  t_coeff             i_cf,
    output logic               o_vld,
    output logic [16:0]        o_b4,
    output logic [31:0]        o_b7,
    output logic signed [15:0] o_t16,
    output logic               o_dz
);

    logic               r_vld [MID_STAGES];
    logic signed [15:0] r_t16 [MID_STAGES];
    logic               r_dz  [MID_STAGES];
    logic [18:0]        r_up  [6];

    logic signed [29:0] r0_b6;
    logic signed [59:0] r1_sq;
    logic signed [29:0] r1_b6;
    logic [46:0]        r2_b6sq;
    logic signed [45:0] r2_xa2;
    logic signed [29:0] r2_b6;
    logic signed [40:0] r3_pb2l;
    logic signed [39:0] r3_pb2h;
    logic [46:0]        r3_b6sq;
    logic signed [45:0] r3_xa2;
    logic signed [29:0] r3_b6;
    logic signed [53:0] r4_v;
    logic signed [40:0] r4_pb1l;
    logic signed [39:0] r4_pb1h;
    logic signed [29:0] r4_b6;
    logic [31:0]        r5_b3lo;
    logic signed [32:0] r5_x1b;
    logic signed [46:0] r5_x2b;
    logic [31:0]        r6_c;
    logic [31:0]        r6_dup;
    logic [16:0]        r7_b4;
    logic [31:0]        r7_dup;
    logic [16:0]        r8_b4;
    logic [31:0]        r8_b7;

    logic signed [29:0] s_tr;
    logic signed [25:0] s_tsh;
    logic signed [15:0] s_tsat;
    logic signed [62:0] s_prod_b2;
    logic signed [51:0] s_x1a;
    logic signed [52:0] s_x3a;
    logic signed [57:0] s_w;
    logic signed [57:0] s_wq;
    logic signed [45:0] s_ac3b6;
    logic signed [62:0] s_prod_b1;
    logic signed [47:0] s_sb;
    logic signed [47:0] s_x3b;
    logic signed [47:0] s_cc;
    logic [31:0]        s_m4;
    logic [31:0]        s_scale;

    always_comb begin
        s_tr   = 30'(i_b5) + 30'sd8;
        s_tsh  = 26'(s_tr >>> 4);
        if (s_tsh > 26'sd32767) begin
            s_tsat = 16'sd32767;
        end else if (s_tsh < -26'sd32768) begin
            s_tsat = -16'sd32768;
        end else begin
            s_tsat = s_tsh[15:0];
        end
    end

    always_comb begin
        s_prod_b2 = (63'(r3_pb2h) <<< 24) + 63'(r3_pb2l);
        s_x1a     = 52'(s_prod_b2 >>> 11);
        s_x3a     = 53'(s_x1a) + 53'(r3_xa2 >>> 11);
        // rounding of b3 is toward zero
        s_w       = (58'(r4_v) <<< i_cf.oss) + 58'sd2;
        s_wq      = (s_w + (s_w[57] ? 58'sd3 : 58'sd0)) >>> 2;
        s_ac3b6   = $signed(i_cf.ac3) * r4_b6;
        s_prod_b1 = (63'(r4_pb1h) <<< 24) + 63'(r4_pb1l);
        s_sb      = 48'(r5_x1b) + 48'(r5_x2b) + 48'sd2;
        s_x3b     = s_sb >>> 2;
        s_cc      = s_x3b + 48'(B4_BIAS);
        s_m4      = 32'(i_cf.ac4) * r6_c;
        s_scale   = 32'(P_SCALE) >> i_cf.oss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MID_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < MID_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t16[0] <= s_tsat;
        r_dz[0]  <= i_dz;
        r_up[0]  <= i_up;
        for (int k = 1; k < MID_STAGES; k++) begin
            r_t16[k] <= r_t16[k-1];
            r_dz[k]  <= r_dz[k-1];
        end
        for (int k = 1; k < 6; k++) begin
            r_up[k] <= r_up[k-1];
        end

        r0_b6   <= 30'(i_b5) - 30'(B6_OFFSET);
        r1_sq   <= r0_b6 * r0_b6;
        r1_b6   <= r0_b6;
        r2_b6sq <= r1_sq[58:12];
        r2_xa2  <= $signed(i_cf.ac2) * r1_b6;
        r2_b6   <= r1_b6;
        r3_pb2l <= $signed(i_cf.b2) * $signed({1'b0, r2_b6sq[23:0]});
        r3_pb2h <= $signed(i_cf.b2) * $signed({1'b0, r2_b6sq[46:24]});
        r3_b6sq <= r2_b6sq;
        r3_xa2  <= r2_xa2;
        r3_b6   <= r2_b6;
        r4_v    <= 54'(s_x3a) + (54'($signed(i_cf.ac1)) <<< 2);
        r4_pb1l <= $signed(i_cf.b1) * $signed({1'b0, r3_b6sq[23:0]});
        r4_pb1h <= $signed(i_cf.b1) * $signed({1'b0, r3_b6sq[46:24]});
        r4_b6   <= r3_b6;
        r5_b3lo <= s_wq[31:0];
        r5_x1b  <= 33'(s_ac3b6 >>> 13);
        r5_x2b  <= 47'(s_prod_b1 >>> 16);
        r6_c    <= s_cc[31:0];
        r6_dup  <= {13'b0, r_up[5]} - r5_b3lo;
        r7_b4   <= s_m4[31:15];
        r7_dup  <= r6_dup;
        r8_b4   <= r7_b4;
        r8_b7   <= r7_dup * s_scale;
    end

    assign o_vld = r_vld[MID_STAGES-1];
    assign o_b4  = r8_b4;
    assign o_b7  = r8_b7;
    assign o_t16 = r_t16[MID_STAGES-1];
    assign o_dz  = r_dz[MID_STAGES-1];

endmodule
